// ===== sv/kvt_pkg.sv =====
// shared types and constants of the keyed value table
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

    localparam int DATA_W          = 32;
    localparam int ACTION_W        = 2;
    localparam int ENTRIES_DEFAULT = 64;

    // action codes; the fourth code is unused and does nothing
    localparam logic [ACTION_W-1:0] ACT_SET   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GET   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] new_value;
        logic signed [DATA_W-1:0] fallback_value;
    } kvt_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic                     table_full;
    } kvt_res_t;

endpackage

`default_nettype wire

// ===== sv/keyed_value_table.sv =====
// top level of the keyed value table: memories, search sequencer, result register
`timescale 1ns / 1ps
`default_nettype none

// Keyed value table. Holds up to ENTRIES signed 32-bit key/value pairs in two
// single-port-write, registered-read memories (keys and values). A set request
// overwrites the value of a key already present or appends a new entry; a set
// of a new key into a full table is dropped and reports table_full. A get
// request returns the stored value with found, or its fallback_value on a miss.
// A clear request empties the table in one step (only the fill count resets).
// Every request gives exactly one result. Requests are handled one at a time:
// the key memory is scanned one entry per cycle over the filled entries.
// A request passes from idle through the scan (and, on a get hit, a value
// read) to the result state, which loads the output register; clear and the
// unused action go straight to the result state. The result sits in an
// output register, so a new request is taken while it waits; only the next
// result is held back until the taker drains the register.
module keyed_value_table #(
    parameter int ENTRIES = kvt_pkg::ENTRIES_DEFAULT
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire kvt_pkg::kvt_req_t s_req,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output kvt_pkg::kvt_res_t    m_res
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_VREAD,
        ST_RESULT
    } state_t;

    // storage
    logic [kvt_pkg::DATA_W-1:0] key_mem [ENTRIES];
    logic [kvt_pkg::DATA_W-1:0] val_mem [ENTRIES];

    logic [kvt_pkg::DATA_W-1:0] key_rdata_reg;
    logic [kvt_pkg::DATA_W-1:0] val_rdata_reg;

    // control and request registers
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    kvt_pkg::kvt_req_t req_reg, req_next;
    kvt_pkg::kvt_res_t res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    kvt_pkg::kvt_res_t m_res_reg, m_res_next;

    // memory ports
    logic [IDX_W-1:0]           key_raddr;
    logic [IDX_W-1:0]           val_raddr;
    logic                       key_we, val_we;
    logic [IDX_W-1:0]           wr_addr;

    logic accept;
    logic key_hit;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    // compare the key read last cycle against the request key
    assign key_hit = cmp_valid_reg && (key_rdata_reg == req_reg.key);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_res_next     = m_res_reg;
        key_raddr      = scan_reg[IDX_W-1:0];
        val_raddr      = cmp_idx_reg;
        key_we         = 1'b0;
        val_we         = 1'b0;
        wr_addr        = cmp_idx_reg;

        // the taker drains the output register
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next  = s_req;
                    scan_next = '0;
                    res_next  = '0;
                    unique case (s_req.action) inside
                        kvt_pkg::ACT_SET, kvt_pkg::ACT_GET: begin
                            state_next = ST_SCAN;
                        end
                        kvt_pkg::ACT_CLEAR: begin
                            count_next = '0;
                            state_next = ST_RESULT;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (key_hit) begin
                    res_next.found = 1'b1;
                    if (req_reg.action == kvt_pkg::ACT_GET) begin
                        // fetch the stored value at the matching slot
                        val_raddr  = cmp_idx_reg;
                        state_next = ST_VREAD;
                    end else begin
                        val_we     = 1'b1;
                        wr_addr    = cmp_idx_reg;
                        state_next = ST_RESULT;
                    end
                end else if (scan_reg < count_reg) begin
                    // issue the next key read; compared in the next cycle
                    key_raddr      = scan_reg[IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[IDX_W-1:0];
                    scan_next      = scan_reg + CNT_W'(1);
                end else begin
                    // miss over all filled entries
                    if (req_reg.action == kvt_pkg::ACT_GET) begin
                        res_next.read_value = req_reg.fallback_value;
                    end else if (count_reg < FULL_COUNT) begin
                        key_we     = 1'b1;
                        val_we     = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        res_next.table_full = 1'b1;
                    end
                    state_next = ST_RESULT;
                end
            end

            ST_VREAD: begin
                res_next.read_value = val_rdata_reg;
                state_next          = ST_RESULT;
            end

            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= cmp_idx_next;
        req_reg     <= req_next;
        res_reg     <= res_next;
        m_res_reg   <= m_res_next;
    end

    // key memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[wr_addr] <= req_reg.key;
        end
        key_rdata_reg <= key_mem[key_raddr];
    end

    // value memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[wr_addr] <= req_reg.new_value;
        end
        val_rdata_reg <= val_mem[val_raddr];
    end

    // fill count stays within capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond capacity");

    // a clear empties the table on the next cycle
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_req.action == kvt_pkg::ACT_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the table");

    // a dropped set is only reported when the table is full
    a_full_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT && res_reg.table_full) |-> (count_reg == FULL_COUNT))
        else $error("table_full with free entries");

    // a hit and a dropped set never come together
    a_hit_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_res_reg.found && m_res_reg.table_full))
        else $error("found and table_full both set");

    // a compare is only pending while scanning
    a_cmp_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_valid_reg |-> (state_reg == ST_SCAN))
        else $error("key compare outside of scan");

endmodule

`default_nettype wire
